// ----- src/glos_pkg.sv -----
// ----------------------------------------------------------------------------
// glos_pkg
// Shared types and constants for the grid line-of-sight block.
// ----------------------------------------------------------------------------
package glos_pkg;

   localparam int GRID_DIM_DEF  = 32;
   localparam int FRAC_BITS_DEF = 8;

   localparam int COORD_W = 14;   // fixed-point coordinate width
   localparam int CELL_W  = 5;    // map write column/row width
   localparam int ACC_W   = 32;   // crossing accumulators, wrap mod 2^32

   localparam logic REQ_WRITE = 1'b0;
   localparam logic REQ_QUERY = 1'b1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SETUP,
      ST_WALK,
      ST_DRAIN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic clear_en;      // write one cleared entry of the sweep
      logic write_cell;    // map write word accepted
      logic load;          // query word accepted
      logic setup;         // start walk: tiles, accumulators
      logic issue;         // read current tile, step if not at end
      logic result_load;   // move verdict into output register
   } glos_cmd_type;

   typedef struct packed {
      logic clear_last;    // sweep at last entry
      logic outside;       // an end tile lies off the map
      logic at_end;        // walk sits on the end tile
      logic rd_pend;       // map read data valid this cycle
      logic rd_open;       // map read data
      logic rsp_busy;      // output register full and not taken
   } glos_status_type;

endpackage

// ----- src/glos_ctrl.sv -----
// ----------------------------------------------------------------------------
// glos_ctrl
// Sequencer: map clear sweep, request accept, tile walk, result hand-off.
// ----------------------------------------------------------------------------
module glos_ctrl import glos_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  logic            req_type,
   output logic            req_ready,
   input  glos_status_type status,
   output glos_cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;
   logic      accept;

   assign accept = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept && req_type == REQ_QUERY) begin
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            state_in = status.outside ? ST_DONE : ST_WALK;
         end
         ST_WALK: begin
            if (status.rd_pend && !status.rd_open) begin
               state_in = ST_DONE;
            end else if (status.at_end) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!status.rsp_busy) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // outputs
   always_comb begin
      req_ready = 1'b0;
      cmd       = '0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_en = 1'b1;
         end
         ST_IDLE: begin
            req_ready      = 1'b1;
            cmd.write_cell = accept && req_type == REQ_WRITE;
            cmd.load       = accept && req_type == REQ_QUERY;
         end
         ST_SETUP: begin
            cmd.setup = !status.outside;
         end
         ST_WALK: begin
            cmd.issue = 1'b1;
         end
         ST_DRAIN: begin
            cmd.issue = 1'b0;
         end
         ST_DONE: begin
            cmd.result_load = !status.rsp_busy;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

// ----- src/glos_dp.sv -----
// ----------------------------------------------------------------------------
// glos_dp
// Datapath: tile map memory, walk position, cross-multiplied accumulators
// and output register.
// ----------------------------------------------------------------------------
module glos_dp import glos_pkg::*; #(
   parameter int GRID_DIM  = GRID_DIM_DEF,
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  glos_cmd_type        cmd,
   output glos_status_type     status,
   input  logic [CELL_W-1:0]   req_cell_x,
   input  logic [CELL_W-1:0]   req_cell_y,
   input  logic                req_cell_open,
   input  logic [COORD_W-1:0]  req_start_x,
   input  logic [COORD_W-1:0]  req_start_y,
   input  logic [COORD_W-1:0]  req_end_x,
   input  logic [COORD_W-1:0]  req_end_y,
   input  logic                rsp_ready,
   output logic                rsp_valid,
   output logic                rsp_line_clear,
   output logic                rsp_outside_grid
);

   localparam int IDX_W     = $clog2(GRID_DIM);
   localparam int ADDR_W    = 2 * IDX_W;
   localparam int MEM_DEPTH = 1 << ADDR_W;
   localparam int TILE_W    = COORD_W - FRAC_BITS;
   localparam int DIST_W    = FRAC_BITS + 1;
   localparam logic [DIST_W-1:0] ONE_TILE = DIST_W'(1) << FRAC_BITS;

   // tile map
   logic mem [MEM_DEPTH];
   logic [ADDR_W-1:0] clr_addr_ff, clr_addr_in;
   logic [ADDR_W-1:0] wr_addr;
   logic              wr_en;
   logic              wr_data;
   logic              cell_in_map;

   // query operands
   logic              negx_ff, negy_ff;
   logic [COORD_W-1:0] adx_ff, ady_ff;
   logic [DIST_W-1:0] distx_ff, disty_ff;
   logic [IDX_W-1:0]  scol_ff, srow_ff, ecol_ff, erow_ff;
   logic              outside_ff;

   // walk state
   logic [IDX_W-1:0]  walk_col_ff, walk_row_ff;
   logic [IDX_W-1:0]  x_left_ff, y_left_ff;
   logic [ACC_W-1:0]  acc_x_ff, acc_y_ff;
   logic [ACC_W-1:0]  acc_diff;
   logic              at_end, step_x;

   logic              rd_pend_ff, rd_open_ff, hit_block_ff;
   logic              rsp_valid_ff, rsp_clear_ff, rsp_out_ff;

   // load-side decode
   logic               negx, negy;
   logic [TILE_W-1:0]  scol_t, srow_t, ecol_t, erow_t;
   logic [FRAC_BITS-1:0] fx, fy;
   logic               outside;

   assign negx   = req_end_x < req_start_x;
   assign negy   = req_end_y < req_start_y;
   assign scol_t = req_start_x[COORD_W-1:FRAC_BITS];
   assign srow_t = req_start_y[COORD_W-1:FRAC_BITS];
   assign ecol_t = req_end_x[COORD_W-1:FRAC_BITS];
   assign erow_t = req_end_y[COORD_W-1:FRAC_BITS];
   assign fx     = req_start_x[FRAC_BITS-1:0];
   assign fy     = req_start_y[FRAC_BITS-1:0];
   assign outside = (32'(scol_t) >= 32'(GRID_DIM)) || (32'(srow_t) >= 32'(GRID_DIM)) ||
                    (32'(ecol_t) >= 32'(GRID_DIM)) || (32'(erow_t) >= 32'(GRID_DIM));

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         negx_ff    <= negx;
         negy_ff    <= negy;
         adx_ff     <= negx ? req_start_x - req_end_x : req_end_x - req_start_x;
         ady_ff     <= negy ? req_start_y - req_end_y : req_end_y - req_start_y;
         distx_ff   <= negx ? DIST_W'(fx) : ONE_TILE - DIST_W'(fx);
         disty_ff   <= negy ? DIST_W'(fy) : ONE_TILE - DIST_W'(fy);
         scol_ff    <= IDX_W'(scol_t);
         srow_ff    <= IDX_W'(srow_t);
         ecol_ff    <= IDX_W'(ecol_t);
         erow_ff    <= IDX_W'(erow_t);
         outside_ff <= outside;
      end
   end

   // step choice: a finished axis never steps; a tie steps in y
   assign at_end   = (x_left_ff == '0) && (y_left_ff == '0);
   assign acc_diff = acc_x_ff - acc_y_ff;
   always_comb begin
      if (y_left_ff == '0) begin
         step_x = 1'b1;
      end else if (x_left_ff == '0) begin
         step_x = 1'b0;
      end else begin
         step_x = acc_diff[ACC_W-1];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.setup) begin
         walk_col_ff <= scol_ff;
         walk_row_ff <= srow_ff;
         x_left_ff   <= negx_ff ? scol_ff - ecol_ff : ecol_ff - scol_ff;
         y_left_ff   <= negy_ff ? srow_ff - erow_ff : erow_ff - srow_ff;
         acc_x_ff    <= ACC_W'(distx_ff * ACC_W'(ady_ff));
         acc_y_ff    <= ACC_W'(disty_ff * ACC_W'(adx_ff));
      end else if (cmd.issue && !at_end) begin
         if (step_x) begin
            walk_col_ff <= negx_ff ? walk_col_ff - 1'b1 : walk_col_ff + 1'b1;
            x_left_ff   <= x_left_ff - 1'b1;
            acc_x_ff    <= acc_x_ff + (ACC_W'(ady_ff) << FRAC_BITS);
         end else begin
            walk_row_ff <= negy_ff ? walk_row_ff - 1'b1 : walk_row_ff + 1'b1;
            y_left_ff   <= y_left_ff - 1'b1;
            acc_y_ff    <= acc_y_ff + (ACC_W'(adx_ff) << FRAC_BITS);
         end
      end
   end

   // map write port: clear sweep or cell write
   assign cell_in_map = (32'(req_cell_x) < 32'(GRID_DIM)) && (32'(req_cell_y) < 32'(GRID_DIM));
   assign wr_en       = cmd.clear_en || (cmd.write_cell && cell_in_map);
   assign wr_addr     = cmd.clear_en ? clr_addr_ff
                                     : {IDX_W'(req_cell_y), IDX_W'(req_cell_x)};
   assign wr_data     = cmd.clear_en ? 1'b0 : req_cell_open;
   assign clr_addr_in = clr_addr_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.issue) begin
         rd_open_ff <= mem[{walk_row_ff, walk_col_ff}];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff  <= '0;
         rd_pend_ff   <= 1'b0;
         hit_block_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.clear_en) begin
            clr_addr_ff <= clr_addr_in;
         end
         rd_pend_ff <= cmd.issue;
         if (cmd.load) begin
            hit_block_ff <= 1'b0;
         end else if (rd_pend_ff && !rd_open_ff) begin
            hit_block_ff <= 1'b1;
         end
         if (cmd.result_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.result_load) begin
         rsp_clear_ff <= !outside_ff && !hit_block_ff;
         rsp_out_ff   <= outside_ff;
      end
   end

   assign status.clear_last = (clr_addr_ff == ADDR_W'(MEM_DEPTH - 1));
   assign status.outside    = outside_ff;
   assign status.at_end     = at_end;
   assign status.rd_pend    = rd_pend_ff;
   assign status.rd_open    = rd_open_ff;
   assign status.rsp_busy   = rsp_valid_ff && !rsp_ready;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_line_clear   = rsp_clear_ff;
   assign rsp_outside_grid = rsp_out_ff;

endmodule

// ----- src/grid_line_of_sight_dda_top.sv -----
// ----------------------------------------------------------------------------
// grid_line_of_sight_dda_top
// Tile map with line-of-sight queries by 2D grid traversal.
//
//  channel | direction | word contents
//  --------+-----------+------------------------------------------------------
//  req_    | in        | req_type, cell x/y/open, start x/y, end x/y
//  rsp_    | out       | line_clear, outside_grid (one word per query)
//
// After reset the map is swept to blocked, one entry per cycle:
// 2^(2*clog2(GRID_DIM)) entries (1024 at 32x32); no word is taken meanwhile.
// A query walks N tiles, N = 1 .. 2*GRID_DIM-1, with one map read per tile,
// overlapped with the step. An off-map query skips the walk. A finished
// result waits in the output register; new writes are taken while it waits,
// a new query can finish only once the register is free.
// ----------------------------------------------------------------------------
module grid_line_of_sight_dda_top import glos_pkg::*; #(
   parameter int GRID_DIM  = GRID_DIM_DEF,
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_type,
   input  logic [CELL_W-1:0]  req_cell_x,
   input  logic [CELL_W-1:0]  req_cell_y,
   input  logic               req_cell_open,
   input  logic [COORD_W-1:0] req_start_x,
   input  logic [COORD_W-1:0] req_start_y,
   input  logic [COORD_W-1:0] req_end_x,
   input  logic [COORD_W-1:0] req_end_y,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_line_clear,
   output logic               rsp_outside_grid
);

   glos_cmd_type    cmd;
   glos_status_type status;

   // sequencer
   glos_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_type  (req_type),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // map, walk and output register
   glos_dp #(
      .GRID_DIM  (GRID_DIM),
      .FRAC_BITS (FRAC_BITS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_cell_x       (req_cell_x),
      .req_cell_y       (req_cell_y),
      .req_cell_open    (req_cell_open),
      .req_start_x      (req_start_x),
      .req_start_y      (req_start_y),
      .req_end_x        (req_end_x),
      .req_end_y        (req_end_y),
      .rsp_ready        (rsp_ready),
      .rsp_valid        (rsp_valid),
      .rsp_line_clear   (rsp_line_clear),
      .rsp_outside_grid (rsp_outside_grid)
   );

endmodule

// ----- test/grid_line_of_sight_dda_top_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_line_of_sight_dda_top_test
// Self-checking bench for the grid line-of-sight block. A tile map and a
// cross-multiplied grid walk are kept in a scoreboard and updated on every
// accepted request word. Each response word is matched against the oldest
// predicted verdict. Directed segments are sent first, then random map loads
// and queries inside random windows. Both sides stall at random.
// ----------------------------------------------------------------------------
module grid_line_of_sight_dda_top_test;
   import glos_pkg::*;

   localparam int GRID     = GRID_DIM_DEF;
   localparam int FRAC     = FRAC_BITS_DEF;
   localparam int TILE_W   = COORD_W - FRAC;
   localparam int ONE_TILE = 1 << FRAC;
   localparam int COORD_MAX = (1 << COORD_W) - 1;
   localparam int WORD_TARGET = 1750;
   localparam int CYCLE_LIMIT = 1000000;

   // One request word as presented on the req_ channel.
   typedef struct packed {
      logic               kind;
      logic [CELL_W-1:0]  cell_x;
      logic [CELL_W-1:0]  cell_y;
      logic               cell_open;
      logic [COORD_W-1:0] start_x;
      logic [COORD_W-1:0] start_y;
      logic [COORD_W-1:0] end_x;
      logic [COORD_W-1:0] end_y;
   } los_word_type;

   typedef struct packed {
      logic line_clear;
      logic outside_grid;
   } verdict_type;

   // Holds the predicted tile map and walk state, plus verdicts still owed.
   class los_scoreboard;
      bit                tile_map [GRID*GRID];
      logic [TILE_W-1:0] walk_col;
      logic [TILE_W-1:0] walk_row;
      logic [ACC_W-1:0]  cross_x;
      logic [ACC_W-1:0]  cross_y;
      verdict_type       verdicts_q [$];
      int                failures;

      function new();
         foreach (tile_map[i]) tile_map[i] = 1'b0;
         walk_col = '0;
         walk_row = '0;
         cross_x  = '0;
         cross_y  = '0;
         failures = 0;
      endfunction

      function int pending();
         return verdicts_q.size();
      endfunction

      // Walk the tiles crossed by the segment; exact, no division.
      function verdict_type trace_line(los_word_type w);
         logic [TILE_W-1:0]  scol, srow, ecol, erow, x_left, y_left;
         logic [COORD_W-1:0] adx, ady;
         logic [ACC_W-1:0]   dist_x, dist_y, diff;
         logic               negx, negy, step_x, done;
         verdict_type        v;
         scol = w.start_x[COORD_W-1:FRAC];
         srow = w.start_y[COORD_W-1:FRAC];
         ecol = w.end_x[COORD_W-1:FRAC];
         erow = w.end_y[COORD_W-1:FRAC];
         negx = w.end_x < w.start_x;
         negy = w.end_y < w.start_y;
         adx  = negx ? w.start_x - w.end_x : w.end_x - w.start_x;
         ady  = negy ? w.start_y - w.end_y : w.end_y - w.start_y;
         v.line_clear   = 1'b1;
         v.outside_grid = 1'b0;
         if (scol >= GRID || srow >= GRID || ecol >= GRID || erow >= GRID) begin
            v.line_clear   = 1'b0;
            v.outside_grid = 1'b1;
            return v;
         end
         x_left   = negx ? scol - ecol : ecol - scol;
         y_left   = negy ? srow - erow : erow - srow;
         walk_col = scol;
         walk_row = srow;
         // distance to first crossing: fraction going down, rest going up
         dist_x = negx ? ACC_W'(w.start_x[FRAC-1:0])
                       : ACC_W'(ONE_TILE) - ACC_W'(w.start_x[FRAC-1:0]);
         dist_y = negy ? ACC_W'(w.start_y[FRAC-1:0])
                       : ACC_W'(ONE_TILE) - ACC_W'(w.start_y[FRAC-1:0]);
         cross_x = dist_x * ACC_W'(ady);
         cross_y = dist_y * ACC_W'(adx);
         done = 1'b0;
         while (!done) begin
            if (!tile_map[int'(walk_row) * GRID + int'(walk_col)]) begin
               v.line_clear = 1'b0;
               done = 1'b1;
            end else if (x_left == 0 && y_left == 0) begin
               done = 1'b1;
            end else begin
               diff = cross_x - cross_y;
               if (y_left == 0)
                  step_x = 1'b1;
               else if (x_left == 0)
                  step_x = 1'b0;
               else
                  step_x = diff[ACC_W-1];   // tie goes to y
               if (step_x) begin
                  walk_col = negx ? walk_col - 1'b1 : walk_col + 1'b1;
                  x_left   = x_left - 1'b1;
                  cross_x  = cross_x + ACC_W'(ONE_TILE) * ACC_W'(ady);
               end else begin
                  walk_row = negy ? walk_row - 1'b1 : walk_row + 1'b1;
                  y_left   = y_left - 1'b1;
                  cross_y  = cross_y + ACC_W'(ONE_TILE) * ACC_W'(adx);
               end
            end
         end
         return v;
      endfunction

      function void note_word(los_word_type w);
         if (w.kind == REQ_WRITE) begin
            if (w.cell_x < GRID && w.cell_y < GRID)
               tile_map[int'(w.cell_y) * GRID + int'(w.cell_x)] = w.cell_open;
         end else begin
            verdicts_q = {verdicts_q, trace_line(w)};
         end
      endfunction

      function void check_result(logic line_clear, logic outside_grid);
         verdict_type exp_v;
         if (verdicts_q.size() == 0) begin
            $error("rsp word with no query outstanding");
            failures++;
            return;
         end
         exp_v = verdicts_q.pop_front();
         if (line_clear !== exp_v.line_clear) begin
            $error("line_clear: expected %0d, actual %0d", exp_v.line_clear, line_clear);
            failures++;
         end
         if (outside_grid !== exp_v.outside_grid) begin
            $error("outside_grid: expected %0d, actual %0d",
                   exp_v.outside_grid, outside_grid);
            failures++;
         end
      endfunction
   endclass

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic               req_type = REQ_WRITE;
   logic [CELL_W-1:0]  req_cell_x = '0;
   logic [CELL_W-1:0]  req_cell_y = '0;
   logic               req_cell_open = 1'b0;
   logic [COORD_W-1:0] req_start_x = '0;
   logic [COORD_W-1:0] req_start_y = '0;
   logic [COORD_W-1:0] req_end_x = '0;
   logic [COORD_W-1:0] req_end_y = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic               rsp_line_clear;
   logic               rsp_outside_grid;

   los_scoreboard sb = new;
   int            words_sent = 0;
   int            cycle_count = 0;
   bit            steady = 1'b0;   // no stalls on either side while set

   grid_line_of_sight_dda_top uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_type         (req_type),
      .req_cell_x       (req_cell_x),
      .req_cell_y       (req_cell_y),
      .req_cell_open    (req_cell_open),
      .req_start_x      (req_start_x),
      .req_start_y      (req_start_y),
      .req_end_x        (req_end_x),
      .req_end_y        (req_end_y),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_line_clear   (rsp_line_clear),
      .rsp_outside_grid (rsp_outside_grid)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Watchdog: covers the post-reset map sweep and every worst-case walk
   // many times over.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("grid_line_of_sight_dda_top_test failed");
         $finish;
      end
   end

   // Response side: check on a taken word, then pick the next ready.
   // Values read here are the ones settled before this edge.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_result(rsp_line_clear, rsp_outside_grid);
      rsp_ready <= steady || ($urandom_range(0, 99) >= 13);
   end

   // Present one word and hold it until taken. Valid only drops across an
   // idle gap, so back-to-back words keep it high.
   task automatic send_word(input los_word_type w);
      while (!steady && $urandom_range(0, 99) < 13) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_type      <= w.kind;
      req_cell_x    <= w.cell_x;
      req_cell_y    <= w.cell_y;
      req_cell_open <= w.cell_open;
      req_start_x   <= w.start_x;
      req_start_y   <= w.start_y;
      req_end_x     <= w.end_x;
      req_end_y     <= w.end_y;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_word(w);
      words_sent++;
   endtask

   // Map write; coordinate fields carry junk the block must ignore.
   task automatic put_cell(input int cx, input int cy, input bit open_bit);
      los_word_type w;
      w.kind      = REQ_WRITE;
      w.cell_x    = CELL_W'(cx);
      w.cell_y    = CELL_W'(cy);
      w.cell_open = open_bit;
      w.start_x   = COORD_W'($urandom);
      w.start_y   = COORD_W'($urandom);
      w.end_x     = COORD_W'($urandom);
      w.end_y     = COORD_W'($urandom);
      send_word(w);
   endtask

   // Query; cell fields carry junk.
   task automatic ask_los(input int sx, input int sy, input int ex, input int ey);
      los_word_type w;
      w.kind      = REQ_QUERY;
      w.cell_x    = CELL_W'($urandom);
      w.cell_y    = CELL_W'($urandom);
      w.cell_open = 1'($urandom);
      w.start_x   = COORD_W'(sx);
      w.start_y   = COORD_W'(sy);
      w.end_x     = COORD_W'(ex);
      w.end_y     = COORD_W'(ey);
      send_word(w);
   endtask

   // Center of a tile in fixed point.
   function automatic int mid(int t);
      return t * ONE_TILE + ONE_TILE / 2;
   endfunction

   function automatic int clamp_coord(int v);
      if (v < 0) return 0;
      if (v > COORD_MAX) return COORD_MAX;
      return v;
   endfunction

   initial begin
      int wsize, wx0, wy0, density, n_wr, n_q, sx, sy, ex, ey, d;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // --- directed ---
      ask_los(mid(0), mid(0), mid(0), mid(0));         // map still all blocked
      put_cell(0, 0, 1'b1);
      ask_los(mid(0), mid(0), mid(0), mid(0));         // same start and end tile
      put_cell(1, 0, 1'b1);
      put_cell(2, 0, 1'b1);
      put_cell(3, 0, 1'b1);
      ask_los(mid(0), mid(0), mid(3), mid(0));         // dy = 0, walk in x only
      ask_los(mid(3), mid(0), 0, 0);                   // negative x to the origin
      put_cell(0, 1, 1'b1);
      put_cell(1, 1, 1'b1);
      ask_los(mid(0), mid(0), mid(1), mid(1));         // corner tie, y steps
      put_cell(0, 1, 1'b0);
      ask_los(mid(0), mid(0), mid(1), mid(1));         // tie steps into a wall
      ask_los(mid(1), mid(1), mid(0), mid(0));         // both negative, tie
      ask_los(mid(0), mid(0), mid(0), mid(1));         // dx = 0, end blocked
      put_cell(31, 31, 1'b1);
      ask_los(mid(31), mid(31), 32 * ONE_TILE - 1, 32 * ONE_TILE - 1);
      ask_los(0, 0, COORD_MAX, 0);                     // end off the map
      ask_los(32 * ONE_TILE, 0, 0, 0);                 // start off the map
      ask_los(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
      put_cell(31, 0, 1'b0);
      put_cell(0, 31, 1'b1);
      ask_los(mid(0), mid(0), mid(31), mid(0));        // long run into blocked
      ask_los(mid(0), mid(31), 0, 0);                  // long vertical

      // --- random: map loads and queries inside a moving window ---
      while (words_sent < WORD_TARGET) begin
         wsize = ($urandom_range(0, 5) == 0) ? GRID : $urandom_range(2, 12);
         wx0 = $urandom_range(0, GRID - wsize);
         wy0 = $urandom_range(0, GRID - wsize);
         case ($urandom_range(0, 3))
            0: density = 50;
            1: density = 80;
            2: density = 95;
            default: density = 100;
         endcase
         n_wr = $urandom_range(4, 24);
         n_q  = $urandom_range(4, 24);
         for (int i = 0; i < n_wr; i++) begin
            steady = (words_sent >= 700 && words_sent < 1000);
            if ($urandom_range(0, 9) == 0)
               put_cell($urandom_range(0, GRID - 1), $urandom_range(0, GRID - 1),
                        1'($urandom));
            else
               put_cell(wx0 + $urandom_range(0, wsize - 1),
                        wy0 + $urandom_range(0, wsize - 1),
                        $urandom_range(0, 99) < density);
         end
         for (int i = 0; i < n_q; i++) begin
            steady = (words_sent >= 700 && words_sent < 1000);
            sx = (wx0 + $urandom_range(0, wsize - 1)) * ONE_TILE
                 + $urandom_range(0, ONE_TILE - 1);
            sy = (wy0 + $urandom_range(0, wsize - 1)) * ONE_TILE
                 + $urandom_range(0, ONE_TILE - 1);
            ex = (wx0 + $urandom_range(0, wsize - 1)) * ONE_TILE
                 + $urandom_range(0, ONE_TILE - 1);
            ey = (wy0 + $urandom_range(0, wsize - 1)) * ONE_TILE
                 + $urandom_range(0, ONE_TILE - 1);
            case ($urandom_range(0, 19))
               0, 1, 2: begin
                  // anywhere in the coordinate range, mostly off the map
                  sx = $urandom_range(0, COORD_MAX);
                  sy = $urandom_range(0, COORD_MAX);
                  ex = $urandom_range(0, COORD_MAX);
                  ey = $urandom_range(0, COORD_MAX);
               end
               3, 4, 5: begin
                  // short hop, often within one tile or along an axis
                  ex = clamp_coord(sx + $urandom_range(0, 1200) - 600);
                  ey = ($urandom_range(0, 3) == 0) ? sy
                       : clamp_coord(sy + $urandom_range(0, 1200) - 600);
               end
               6, 7, 8: begin
                  // exact diagonal from a tile center: ties at every corner
                  sx = mid(wx0 + $urandom_range(0, wsize - 1));
                  sy = mid(wy0 + $urandom_range(0, wsize - 1));
                  d  = $urandom_range(0, wsize) * ONE_TILE;
                  ex = clamp_coord($urandom_range(0, 1) ? sx + d : sx - d);
                  ey = clamp_coord($urandom_range(0, 1) ? sy + d : sy - d);
               end
               default: ;
            endcase
            ask_los(sx, sy, ex, ey);
         end
      end
      steady = 1'b0;
      req_valid <= 1'b0;

      // drain, then allow for a walk still in flight
      while (sb.pending() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (sb.failures == 0 && sb.pending() == 0)
         $display("grid_line_of_sight_dda_top_test passed");
      else
         $display("grid_line_of_sight_dda_top_test failed");
      $finish;
   end

endmodule
